/* design/rpq_pkg.sv */
// Shared types, constants and palette lookups for the RGB palette quantizer.
// No dependencies; every design file refers to it by scoped names.
package rpq_pkg;

   localparam int CELL_COUNT  = 256;
   localparam int INDEX_WIDTH = 8;
   localparam int DIST_WIDTH  = 18;
   localparam int SUM_WIDTH   = 15;
   localparam int PROD_WIDTH  = 28;

   // floor(x / 100) for x below 25600 as (x * 5243) >> 19
   localparam int LUMA_RECIP = 5243;
   localparam int LUMA_SHIFT = 19;

   // floor(y / 15) for y below 240 as (y * 137) >> 11
   localparam int GREY_RECIP = 137;
   localparam int GREY_SHIFT = 11;

   localparam logic [7:0] GREY_LOW  = 8'd8;
   localparam logic [7:0] GREY_HIGH = 8'd247;
   localparam logic [7:0] GREY_BASE = 8'd16;
   localparam logic [7:0] BW_SPLIT  = 8'd128;

   localparam logic [7:0] IDX_BLACK = 8'd0;
   localparam logic [7:0] IDX_WHITE = 8'd15;

   localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

   // Method register codes; the codes above BW search all entries
   localparam logic [2:0] METHOD_EUCLID_ALL = 3'd0;
   localparam logic [2:0] METHOD_EUCLID_32  = 3'd1;
   localparam logic [2:0] METHOD_EUCLID_16  = 3'd2;
   localparam logic [2:0] METHOD_GREY       = 3'd3;
   localparam logic [2:0] METHOD_BW         = 3'd4;

   typedef enum logic [1:0] {
      SCOPE_ALL  = 2'd0,
      SCOPE_32   = 2'd1,
      SCOPE_16   = 2'd2,
      SCOPE_NONE = 2'd3
   } scope_type;

   typedef struct packed {
      logic                  valid;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      scope_type             scope;
      logic [7:0]            best_idx;
      logic [DIST_WIDTH-1:0] best_dist;
   } bus_type;

   localparam logic [7:0] LEV_RED   [7]  = '{8'd18, 8'd55, 8'd91, 8'd128, 8'd164, 8'd200,
                                             8'd237};
   localparam logic [7:0] LEV_GREEN [8]  = '{8'd16, 8'd48, 8'd80, 8'd112, 8'd143, 8'd175,
                                             8'd207, 8'd239};
   localparam logic [7:0] LEV_BLUE  [4]  = '{8'd32, 8'd96, 8'd159, 8'd223};
   localparam logic [7:0] SYS_GREEN [4]  = '{8'd0, 8'd85, 8'd170, 8'd255};
   localparam logic [7:0] GREY_LEV  [16] = '{8'd15, 8'd30, 8'd45, 8'd60, 8'd75, 8'd90,
                                             8'd105, 8'd120, 8'd135, 8'd150, 8'd165,
                                             8'd180, 8'd195, 8'd210, 8'd225, 8'd240};

   function automatic logic [7:0] pal_red(input logic [7:0] idx);
      logic [7:0] color;
      if (idx > 8'd31) begin
         color = LEV_RED[idx[7:5] - 3'd1];
      end else if (idx > 8'd15) begin
         color = GREY_LEV[idx[3:0]];
      end else begin
         color = idx[2] ? 8'd255 : 8'd0;
      end
      return color;
   endfunction

   function automatic logic [7:0] pal_green(input logic [7:0] idx);
      logic [7:0] color;
      if (idx > 8'd31) begin
         color = LEV_GREEN[idx[3:1]];
      end else if (idx > 8'd15) begin
         color = GREY_LEV[idx[3:0]];
      end else begin
         color = SYS_GREEN[{idx[3], idx[1]}];
      end
      return color;
   endfunction

   function automatic logic [7:0] pal_blue(input logic [7:0] idx);
      logic [7:0] color;
      if (idx > 8'd31) begin
         color = LEV_BLUE[{idx[4], idx[0]}];
      end else if (idx > 8'd15) begin
         color = GREY_LEV[idx[3:0]];
      end else begin
         color = idx[0] ? 8'd255 : 8'd0;
      end
      return color;
   endfunction

endpackage

/* design/rpq_front.sv */
// Entry stages: luma, luma-based index and search scope for each pixel.
// Uses rpq_pkg; feeds the first cell of the search chain.
module rpq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [7:0]       in_red,
   input  logic [7:0]       in_green,
   input  logic [7:0]       in_blue,
   input  logic [2:0]       method,
   output rpq_pkg::bus_type bus_out
);

   logic                             valid1_ff;
   logic [7:0]                       red1_ff, green1_ff, blue1_ff;
   logic [2:0]                       method1_ff;
   logic [rpq_pkg::SUM_WIDTH-1:0]    sum1_ff;
   logic [rpq_pkg::SUM_WIDTH-1:0]    sum1_in;

   logic                             valid2_ff;
   logic [7:0]                       red2_ff, green2_ff, blue2_ff;
   logic [2:0]                       method2_ff;
   logic [7:0]                       luma2_ff;
   logic [rpq_pkg::PROD_WIDTH-1:0]   prod2;

   logic [7:0]                       grey_off;
   logic [15:0]                      grey_prod;
   logic [7:0]                       grey_idx;
   rpq_pkg::bus_type                 bus_ff;
   rpq_pkg::bus_type                 bus_in;

   // weighted channel sum, at most 25500
   assign sum1_in = rpq_pkg::SUM_WIDTH'(in_red)   * rpq_pkg::SUM_WIDTH'(30)
                  + rpq_pkg::SUM_WIDTH'(in_green) * rpq_pkg::SUM_WIDTH'(59)
                  + rpq_pkg::SUM_WIDTH'(in_blue)  * rpq_pkg::SUM_WIDTH'(11);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red1_ff    <= in_red;
         green1_ff  <= in_green;
         blue1_ff   <= in_blue;
         method1_ff <= method;
         sum1_ff    <= sum1_in;
      end
   end

   assign prod2 = rpq_pkg::PROD_WIDTH'(sum1_ff)
                * rpq_pkg::PROD_WIDTH'(rpq_pkg::LUMA_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (advance) begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red2_ff    <= red1_ff;
         green2_ff  <= green1_ff;
         blue2_ff   <= blue1_ff;
         method2_ff <= method1_ff;
         luma2_ff   <= prod2[rpq_pkg::LUMA_SHIFT +: 8];
      end
   end

   assign grey_off  = luma2_ff - rpq_pkg::GREY_LOW;
   assign grey_prod = 16'(grey_off) * 16'(rpq_pkg::GREY_RECIP);
   assign grey_idx  = rpq_pkg::GREY_BASE + 8'(grey_prod[15:rpq_pkg::GREY_SHIFT]);

   always_comb begin
      bus_in           = '0;
      bus_in.valid     = valid2_ff;
      bus_in.red       = red2_ff;
      bus_in.green     = green2_ff;
      bus_in.blue      = blue2_ff;
      bus_in.best_dist = rpq_pkg::DIST_MAX;
      bus_in.best_idx  = rpq_pkg::IDX_BLACK;
      case (method2_ff)
         rpq_pkg::METHOD_EUCLID_32: begin
            bus_in.scope = rpq_pkg::SCOPE_32;
         end
         rpq_pkg::METHOD_EUCLID_16: begin
            bus_in.scope = rpq_pkg::SCOPE_16;
         end
         rpq_pkg::METHOD_GREY: begin
            bus_in.scope = rpq_pkg::SCOPE_NONE;
            if (luma2_ff < rpq_pkg::GREY_LOW) begin
               bus_in.best_idx = rpq_pkg::IDX_BLACK;
            end else if (luma2_ff > rpq_pkg::GREY_HIGH) begin
               bus_in.best_idx = rpq_pkg::IDX_WHITE;
            end else begin
               bus_in.best_idx = grey_idx;
            end
         end
         rpq_pkg::METHOD_BW: begin
            bus_in.scope    = rpq_pkg::SCOPE_NONE;
            bus_in.best_idx = (luma2_ff < rpq_pkg::BW_SPLIT) ? rpq_pkg::IDX_BLACK
                                                             : rpq_pkg::IDX_WHITE;
         end
         default: begin
            bus_in.scope = rpq_pkg::SCOPE_ALL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else if (advance) begin
         bus_ff <= bus_in;
      end
   end

   assign bus_out = bus_ff;

endmodule

/* design/rpq_cell.sv */
// One search cell: squared distance to its own palette entry, then keep the
// running minimum. Uses rpq_pkg; instantiated once per entry by the top level.
module rpq_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [rpq_pkg::INDEX_WIDTH-1:0]   entry,
   input  rpq_pkg::bus_type                  bus_in_beat,
   output rpq_pkg::bus_type                  bus_out
);

   logic [7:0]       pal_r, pal_g, pal_b;
   logic [7:0]       diff_r, diff_g, diff_b;
   logic [15:0]      sq_r_ff, sq_g_ff, sq_b_ff;
   rpq_pkg::bus_type mid_ff;

   logic [rpq_pkg::DIST_WIDTH-1:0] sq_sum;
   logic                           active;
   logic                           take;
   rpq_pkg::bus_type               bus_ff;
   rpq_pkg::bus_type               bus_in;

   assign pal_r = rpq_pkg::pal_red(entry);
   assign pal_g = rpq_pkg::pal_green(entry);
   assign pal_b = rpq_pkg::pal_blue(entry);

   assign diff_r = (bus_in_beat.red   > pal_r) ? bus_in_beat.red   - pal_r
                                               : pal_r - bus_in_beat.red;
   assign diff_g = (bus_in_beat.green > pal_g) ? bus_in_beat.green - pal_g
                                               : pal_g - bus_in_beat.green;
   assign diff_b = (bus_in_beat.blue  > pal_b) ? bus_in_beat.blue  - pal_b
                                               : pal_b - bus_in_beat.blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid <= 1'b0;
      end else if (advance) begin
         mid_ff <= bus_in_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_r_ff <= 16'(diff_r) * 16'(diff_r);
         sq_g_ff <= 16'(diff_g) * 16'(diff_g);
         sq_b_ff <= 16'(diff_b) * 16'(diff_b);
      end
   end

   assign sq_sum = rpq_pkg::DIST_WIDTH'(sq_r_ff) + rpq_pkg::DIST_WIDTH'(sq_g_ff)
                 + rpq_pkg::DIST_WIDTH'(sq_b_ff);

   always_comb begin
      case (mid_ff.scope)
         rpq_pkg::SCOPE_ALL:  active = 1'b1;
         rpq_pkg::SCOPE_32:   active = (entry < 8'd32);
         rpq_pkg::SCOPE_16:   active = (entry < 8'd16);
         default:             active = 1'b0;
      endcase
   end

   // strict compare: the lowest index keeps a tie
   assign take = active && (sq_sum < mid_ff.best_dist);

   always_comb begin
      bus_in = mid_ff;
      if (take) begin
         bus_in.best_dist = sq_sum;
         bus_in.best_idx  = entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else if (advance) begin
         bus_ff <= bus_in;
      end
   end

   assign bus_out = bus_ff;

endmodule

/* design/rpq_tail.sv */
// Output stage: per-channel error against the chosen entry, output register.
// Uses rpq_pkg; takes the beat leaving the last search cell.
module rpq_tail (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  rpq_pkg::bus_type bus_in_beat,
   output logic             out_valid,
   output logic [7:0]       out_index,
   output logic signed [8:0] out_err_red,
   output logic signed [8:0] out_err_green,
   output logic signed [8:0] out_err_blue
);

   logic              valid_ff;
   logic [7:0]        index_ff;
   logic signed [8:0] err_r_ff, err_g_ff, err_b_ff;
   logic signed [8:0] err_r_in, err_g_in, err_b_in;

   assign err_r_in = $signed({1'b0, bus_in_beat.red})
                   - $signed({1'b0, rpq_pkg::pal_red(bus_in_beat.best_idx)});
   assign err_g_in = $signed({1'b0, bus_in_beat.green})
                   - $signed({1'b0, rpq_pkg::pal_green(bus_in_beat.best_idx)});
   assign err_b_in = $signed({1'b0, bus_in_beat.blue})
                   - $signed({1'b0, rpq_pkg::pal_blue(bus_in_beat.best_idx)});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= bus_in_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         index_ff <= bus_in_beat.best_idx;
         err_r_ff <= err_r_in;
         err_g_ff <= err_g_in;
         err_b_ff <= err_b_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_index     = index_ff;
   assign out_err_red   = err_r_ff;
   assign out_err_green = err_g_ff;
   assign out_err_blue  = err_b_ff;

endmodule

/* design/rgb_palette_quantizer_core.sv */
// Top level of the RGB palette quantizer: method register, entry stages,
// a row of 256 search cells and the output stage. Uses rpq_pkg and all rpq_ modules.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     req_red, req_green, req_blue
//   rsp      out        rsp_valid / rsp_stall     rsp_index, rsp_err_red/green/blue
//   csr      in         csr_wr_en                 csr_wr_data (method)
//
// One pixel per cycle unless a held result stalls the row; from req to rsp each
// beat passes three luma stages, two stages in each of 256 cells, one output stage.
// Reset is synchronous and clears all valid bits and sets the method to full search.
// A held result (rsp_valid with rsp_stall) freezes the whole row and raises req_stall.
module rgb_palette_quantizer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_index,
   output logic signed [8:0] rsp_err_red,
   output logic signed [8:0] rsp_err_green,
   output logic signed [8:0] rsp_err_blue,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_wr_data
);

   logic             advance;
   logic [2:0]       method_ff;
   rpq_pkg::bus_type chain_bus [rpq_pkg::CELL_COUNT+1];

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= rpq_pkg::METHOD_EUCLID_ALL;
      end else if (csr_wr_en) begin
         method_ff <= csr_wr_data;
      end
   end

   rpq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_red   (req_red),
      .in_green (req_green),
      .in_blue  (req_blue),
      .method   (method_ff),
      .bus_out  (chain_bus[0])
   );

   for (genvar i = 0; i < rpq_pkg::CELL_COUNT; i++) begin : g_cell
      rpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .entry       (rpq_pkg::INDEX_WIDTH'(i)),
         .bus_in_beat (chain_bus[i]),
         .bus_out     (chain_bus[i+1])
      );
   end

   rpq_tail u_tail (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .bus_in_beat   (chain_bus[rpq_pkg::CELL_COUNT]),
      .out_valid     (rsp_valid),
      .out_index     (rsp_index),
      .out_err_red   (rsp_err_red),
      .out_err_green (rsp_err_green),
      .out_err_blue  (rsp_err_blue)
   );

`ifndef ASSERT_OFF
   // entry 0 always competes in a search, so a searched beat has a real distance
   assert property (@(posedge clock) disable iff (reset)
      chain_bus[rpq_pkg::CELL_COUNT].valid
      && chain_bus[rpq_pkg::CELL_COUNT].scope != rpq_pkg::SCOPE_NONE
      |-> chain_bus[rpq_pkg::CELL_COUNT].best_dist != rpq_pkg::DIST_MAX)
      else $error("search beat left the chain without a match");

   assert property (@(posedge clock) disable iff (reset)
      chain_bus[rpq_pkg::CELL_COUNT].valid
      && chain_bus[rpq_pkg::CELL_COUNT].scope == rpq_pkg::SCOPE_16
      |-> chain_bus[rpq_pkg::CELL_COUNT].best_idx < 8'd16)
      else $error("16-entry search picked an entry outside its range");

   assert property (@(posedge clock) disable iff (reset)
      chain_bus[rpq_pkg::CELL_COUNT].valid
      && chain_bus[rpq_pkg::CELL_COUNT].scope == rpq_pkg::SCOPE_32
      |-> chain_bus[rpq_pkg::CELL_COUNT].best_idx < 8'd32)
      else $error("32-entry search picked an entry outside its range");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
